@@ hdl/wts_pkg.sv @@
// ----------------------------------------------------------------------------
// Wind triangle solver package
// Shared widths, the CORDIC arctangent table and the pipeline context type.
// ----------------------------------------------------------------------------
package wts_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int SPEED_BITS   = 16;

    localparam int CORDIC_STEPS = 30;
    localparam int XY_W         = 34;
    localparam int Z_W          = 34;
    localparam int ASIN_W       = ANGLE_BITS - 1;
    localparam int ASIN_STEPS   = ANGLE_BITS - 1;
    localparam int ROOT_W       = SPEED_BITS + 1;
    localparam int SQ_W         = 2 * SPEED_BITS + 2;
    localparam int SQT_W        = 2 * SPEED_BITS + 3;
    localparam int DVD_W        = SPEED_BITS + 31;
    localparam int Q_BITS       = 30;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [31:0]     ONE_Q30     = 32'sd1073741824;
    localparam logic [ASIN_W-1:0]      ASIN_TOP    = {1'b1, {(ANGLE_BITS-2){1'b0}}};
    localparam logic [ANGLE_BITS-1:0]  HALF_TURN   = {1'b1, {(ANGLE_BITS-1){1'b0}}};

    typedef logic signed [31:0] t_q30;

    typedef struct packed {
        logic                    vld;
        logic                    ok;
        logic [ANGLE_BITS-1:0]   h;
        logic [SPEED_BITS-1:0]   b;
        logic [SPEED_BITS-1:0]   c;
        logic [ANGLE_BITS-1:0]   drift;
        t_q30                    sn;
        t_q30                    cs;
        logic [2*SPEED_BITS:0]   sum;
        logic [2*SPEED_BITS-1:0] prod;
        logic [SQ_W-1:0]         term;
        logic [SQ_W-1:0]         sq_rem;
        logic [ROOT_W-1:0]       root;
        logic [DVD_W-1:0]        drem;
        logic                    sat;
        logic [30:0]             m;
        logic [ASIN_W-1:0]       lo;
        logic [ASIN_W-1:0]       hi;
        logic [ASIN_W-1:0]       mid;
        logic                    act;
    } t_ctx;

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/wind_triangle_solver.sv @@
// ----------------------------------------------------------------------------
// Wind triangle solver
// Solves the wind triangle from heading, airspeed, ground track and ground
// speed: law of cosines for wind speed, arcsine search for the wind angle.
//
//   Channel   Dir   Payload
//   s (in)    in    tdata: heading, airspeed, track, ground speed;
//                   tuser: track ok, speed ok
//   m (out)   out   tdata: wind speed, wind direction; tuser: wind valid
//
// One item is taken every cycle while the output is not stalled. Most of the
// pipeline is the CORDIC chains: one for the drift and one per bisection
// step of the arcsine search.
// Reset clears the valid bits of every stage and the output register.
// A stall on the output freezes the whole pipeline, and the input with it,
// for as long as a finished result waits in the output register.
// ----------------------------------------------------------------------------
module wind_triangle_solver
    import wts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,  // heading_angle, air_speed, track_angle, ground_speed
    input  logic [1:0]  i_s_tuser,  // track_ok, speed_ok
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // speed, bearing
    output logic [0:0]  o_m_tuser   // wind_valid
);

    logic w_en;

    t_ctx n_s0;
    t_ctx r_s0;
    t_q30 w_sn;
    t_q30 w_cs;
    t_ctx w_c1;
    t_ctx n_s1;
    t_ctx r_s1;
    t_ctx n_s2;
    t_ctx r_s2;
    t_ctx n_sq0;
    t_ctx r_sq [0:ROOT_W];
    t_ctx n_d0;
    t_ctx r_d0;
    t_ctx n_dv0;
    t_ctx r_dv [0:Q_BITS];
    t_ctx n_a0;
    t_ctx r_a0;
    t_ctx w_as [0:ASIN_STEPS];

    logic [30:0]                w_cm;
    logic [2*SPEED_BITS+30:0]   w_tprod;
    logic [SQ_W-1:0]            w_a2;
    logic [SPEED_BITS-1:0]      w_num;
    logic [30:0]                w_snm;
    logic [DVD_W-1:0]           w_alim;

    t_ctx                  w_f;
    logic [ANGLE_BITS-1:0] w_ang;
    logic [ANGLE_BITS-1:0] w_wang;
    logic [SPEED_BITS-1:0] n_speed;
    logic [ANGLE_BITS-1:0] n_dir;
    logic                  n_wvld;

    logic                  r_out_vld;
    logic [SPEED_BITS-1:0] r_speed;
    logic [ANGLE_BITS-1:0] r_dir;
    logic                  r_wvld;

    assign w_en       = !r_out_vld || i_m_tready;
    assign o_s_tready = w_en;

    always_comb begin
        n_s0       = '0;
        n_s0.vld   = i_s_tvalid;
        n_s0.ok    = i_s_tuser[0] & i_s_tuser[1];
        n_s0.h     = i_s_tdata[ANGLE_BITS-1:0];
        n_s0.b     = i_s_tdata[ANGLE_BITS +: SPEED_BITS];
        n_s0.c     = i_s_tdata[2*ANGLE_BITS+SPEED_BITS +: SPEED_BITS];
        n_s0.drift = i_s_tdata[ANGLE_BITS+SPEED_BITS +: ANGLE_BITS]
                   - i_s_tdata[ANGLE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.vld <= 1'b0;
        end else if (w_en) begin
            r_s0 <= n_s0;
        end
    end

    wts_cordic u_drift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_angle (r_s0.drift),
        .i_ctx   (r_s0),
        .o_sin   (w_sn),
        .o_cos   (w_cs),
        .o_ctx   (w_c1)
    );

    always_comb begin
        n_s1      = w_c1;
        n_s1.sn   = w_sn;
        n_s1.cs   = w_cs;
        n_s1.sum  = (2*SPEED_BITS+1)'(w_c1.b) * (2*SPEED_BITS+1)'(w_c1.b)
                  + (2*SPEED_BITS+1)'(w_c1.c) * (2*SPEED_BITS+1)'(w_c1.c);
        n_s1.prod = (2*SPEED_BITS)'(w_c1.b) * (2*SPEED_BITS)'(w_c1.c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
        end else if (w_en) begin
            r_s1 <= n_s1;
        end
    end

    always_comb begin
        w_cm    = r_s1.cs[31] ? 31'(-r_s1.cs) : r_s1.cs[30:0];
        w_tprod = (2*SPEED_BITS+31)'(r_s1.prod) * (2*SPEED_BITS+31)'(w_cm);
        n_s2      = r_s1;
        n_s2.term = w_tprod[2*SPEED_BITS+30:29];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.vld <= 1'b0;
        end else if (w_en) begin
            r_s2 <= n_s2;
        end
    end

    always_comb begin
        if (!r_s2.cs[31]) begin
            w_a2 = (SQ_W'(r_s2.sum) > r_s2.term) ? SQ_W'(r_s2.sum) - r_s2.term : '0;
        end else begin
            w_a2 = SQ_W'(r_s2.sum) + r_s2.term;
        end
        n_sq0        = r_s2;
        n_sq0.sq_rem = w_a2;
        n_sq0.root   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq[0].vld <= 1'b0;
        end else if (w_en) begin
            r_sq[0] <= n_sq0;
        end
    end

    for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
        localparam int K = ROOT_W - 1 - j;
        logic [SQT_W-1:0] w_trial;
        t_ctx             n_step;
        assign w_trial = (SQT_W'(r_sq[j].root) << (K + 1)) + (SQT_W'(1) << (2 * K));
        always_comb begin
            n_step = r_sq[j];
            if (SQT_W'(r_sq[j].sq_rem) >= w_trial) begin
                n_step.sq_rem = SQ_W'(SQT_W'(r_sq[j].sq_rem) - w_trial);
                n_step.root   = r_sq[j].root | (ROOT_W'(1) << K);
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq[j+1].vld <= 1'b0;
            end else if (w_en) begin
                r_sq[j+1] <= n_step;
            end
        end
    end

    always_comb begin
        w_num = (r_sq[ROOT_W].b < r_sq[ROOT_W].c) ? r_sq[ROOT_W].b : r_sq[ROOT_W].c;
        w_snm = r_sq[ROOT_W].sn[31] ? 31'(-r_sq[ROOT_W].sn) : r_sq[ROOT_W].sn[30:0];
        n_d0      = r_sq[ROOT_W];
        n_d0.drem = DVD_W'(w_num) * DVD_W'(w_snm);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d0.vld <= 1'b0;
        end else if (w_en) begin
            r_d0 <= n_d0;
        end
    end

    assign w_alim = DVD_W'(r_d0.root) << Q_BITS;

    always_comb begin
        n_dv0     = r_d0;
        n_dv0.sat = r_d0.drem >= w_alim;
        n_dv0.m   = (r_d0.drem >= w_alim) ? (31'd1 << Q_BITS) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0].vld <= 1'b0;
        end else if (w_en) begin
            r_dv[0] <= n_dv0;
        end
    end

    for (genvar j = 0; j < Q_BITS; j++) begin : g_div
        localparam int K = Q_BITS - 1 - j;
        logic [DVD_W-1:0] w_sub;
        t_ctx             n_step;
        assign w_sub = DVD_W'(r_dv[j].root) << K;
        always_comb begin
            n_step = r_dv[j];
            if (!r_dv[j].sat && (r_dv[j].drem >= w_sub)) begin
                n_step.drem = r_dv[j].drem - w_sub;
                n_step.m    = r_dv[j].m | (31'd1 << K);
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j+1].vld <= 1'b0;
            end else if (w_en) begin
                r_dv[j+1] <= n_step;
            end
        end
    end

    always_comb begin
        n_a0    = r_dv[Q_BITS];
        n_a0.lo = r_dv[Q_BITS].m[30] ? ASIN_TOP : '0;
        n_a0.hi = ASIN_TOP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a0.vld <= 1'b0;
        end else if (w_en) begin
            r_a0 <= n_a0;
        end
    end

    assign w_as[0] = r_a0;

    for (genvar j = 0; j < ASIN_STEPS; j++) begin : g_asin
        wts_asin_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctx   (w_as[j]),
            .o_ctx   (w_as[j+1])
        );
    end

    assign w_f = w_as[ASIN_STEPS];

    always_comb begin
        w_ang  = w_f.sn[31] ? -ANGLE_BITS'(w_f.lo) : ANGLE_BITS'(w_f.lo);
        w_wang = (w_f.b < w_f.c) ? (HALF_TURN - w_f.drift - w_ang) : w_ang;
        if (!w_f.ok) begin
            n_speed = '0;
            n_dir   = '0;
            n_wvld  = 1'b0;
        end else if (w_f.root == '0) begin
            n_speed = '0;
            n_dir   = w_f.h;
            n_wvld  = 1'b1;
        end else begin
            n_speed = w_f.root[ROOT_W-1] ? '1 : w_f.root[SPEED_BITS-1:0];
            n_dir   = w_f.h - w_wang;
            n_wvld  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_f.vld;
            r_speed   <= n_speed;
            r_dir     <= n_dir;
            r_wvld    <= n_wvld;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_dir, r_speed};
    assign o_m_tuser  = r_wvld;

endmodule

@@ hdl/wts_cordic.sv @@
// ----------------------------------------------------------------------------
// Pipelined rotation CORDIC
// Sine and cosine of a binary angle in Q2.30, one iteration per stage, with
// the item context carried alongside.
// ----------------------------------------------------------------------------
module wts_cordic
    import wts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [ANGLE_BITS-1:0] i_angle,
    input  t_ctx                  i_ctx,
    output t_q30                  o_sin,
    output t_q30                  o_cos,
    output t_ctx                  o_ctx
);

    localparam logic signed [XY_W-1:0] POS_LIM = XY_W'(ONE_Q30);
    localparam logic signed [XY_W-1:0] NEG_LIM = -POS_LIM;

    logic [31:0] w_u;
    logic        w_fold;
    logic [31:0] w_uf;

    logic signed [XY_W-1:0] r_x   [0:CORDIC_STEPS];
    logic signed [XY_W-1:0] r_y   [0:CORDIC_STEPS];
    logic signed [Z_W-1:0]  r_z   [0:CORDIC_STEPS];
    logic                   r_neg [0:CORDIC_STEPS];
    t_ctx                   r_ctx [0:CORDIC_STEPS];

    t_q30 w_xc;
    t_q30 w_yc;
    t_q30 r_sin;
    t_q30 r_cos;
    t_ctx r_out;

    assign w_u    = {i_angle, {(32-ANGLE_BITS){1'b0}}};
    assign w_fold = w_u[31] ^ w_u[30];
    assign w_uf   = w_u ^ {w_fold, 31'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx[0].vld <= 1'b0;
        end else if (i_en) begin
            r_x[0]   <= CORDIC_GAIN;
            r_y[0]   <= '0;
            r_z[0]   <= {{(Z_W-32){w_uf[31]}}, w_uf};
            r_neg[0] <= w_fold;
            r_ctx[0] <= i_ctx;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctx[i+1].vld <= 1'b0;
            end else if (i_en) begin
                if (!r_z[i][Z_W-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - $signed({{(Z_W-32){1'b0}}, atan_turn(i)});
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + $signed({{(Z_W-32){1'b0}}, atan_turn(i)});
                end
                r_neg[i+1] <= r_neg[i];
                r_ctx[i+1] <= r_ctx[i];
            end
        end
    end

    always_comb begin
        if (r_x[CORDIC_STEPS] > POS_LIM) begin
            w_xc = ONE_Q30;
        end else if (r_x[CORDIC_STEPS] < NEG_LIM) begin
            w_xc = -ONE_Q30;
        end else begin
            w_xc = r_x[CORDIC_STEPS][31:0];
        end
        if (r_y[CORDIC_STEPS] > POS_LIM) begin
            w_yc = ONE_Q30;
        end else if (r_y[CORDIC_STEPS] < NEG_LIM) begin
            w_yc = -ONE_Q30;
        end else begin
            w_yc = r_y[CORDIC_STEPS][31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.vld <= 1'b0;
        end else if (i_en) begin
            r_sin <= r_neg[CORDIC_STEPS] ? -w_yc : w_yc;
            r_cos <= r_neg[CORDIC_STEPS] ? -w_xc : w_xc;
            r_out <= r_ctx[CORDIC_STEPS];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;
    assign o_ctx = r_out;

endmodule

@@ hdl/wts_asin_step.sv @@
// ----------------------------------------------------------------------------
// Arcsine search step
// One bisection step of the arcsine search: the CORDIC sine of the midpoint
// is compared with the argument and the interval is narrowed.
// ----------------------------------------------------------------------------
module wts_asin_step
    import wts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_ctx i_ctx,
    output t_ctx o_ctx
);

    t_ctx                  r_pre;
    t_ctx                  n_pre;
    logic [ANGLE_BITS-1:0] w_mid_sum;
    t_q30                  w_sin;
    t_q30                  w_cos;
    t_ctx                  w_cctx;
    t_ctx                  r_post;
    t_ctx                  n_post;

    always_comb begin
        w_mid_sum = ANGLE_BITS'(i_ctx.lo) + ANGLE_BITS'(i_ctx.hi) + ANGLE_BITS'(1);
        n_pre     = i_ctx;
        n_pre.act = i_ctx.lo < i_ctx.hi;
        n_pre.mid = w_mid_sum[ANGLE_BITS-1:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre.vld <= 1'b0;
        end else if (i_en) begin
            r_pre <= n_pre;
        end
    end

    wts_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_angle (ANGLE_BITS'(r_pre.mid)),
        .i_ctx   (r_pre),
        .o_sin   (w_sin),
        .o_cos   (w_cos),
        .o_ctx   (w_cctx)
    );

    always_comb begin
        n_post = w_cctx;
        if (w_cctx.act) begin
            if (w_sin <= $signed({1'b0, w_cctx.m})) begin
                n_post.lo = w_cctx.mid;
            end else begin
                n_post.hi = w_cctx.mid - ASIN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_post.vld <= 1'b0;
        end else if (i_en) begin
            r_post <= n_post;
        end
    end

    assign o_ctx = r_post;

endmodule

@@ test/wind_triangle_solver_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wind triangle solver testbench
// Drives heading, airspeed, track and ground speed items into the solver and
// checks each wind result against a bit-accurate CORDIC and arcsine model.
// The run covers invalid flags, zero wind and the arcsine clamp, then random
// items with random idling, a long output stall and a full drain pause.
// ----------------------------------------------------------------------------
module wind_triangle_solver_tb;
    import wts_pkg::*;

    localparam int  HALF_PERIOD = 4;
    localparam int  TAIL_CYCLES = 700;
    localparam int  CYCLE_LIMIT = 600000;
    localparam longint Q30      = 64'sd1 << 30;

    typedef struct packed {
        logic [SPEED_BITS-1:0] speed;
        logic [ANGLE_BITS-1:0] dir;
        logic                  vld;
    } t_wind;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata = '0;  // heading, airspeed, track, ground speed
    logic [1:0]  i_s_tuser = '0;  // track ok, speed ok
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;       // speed, bearing
    logic [0:0]  o_m_tuser;       // wind valid

    t_wind  wind_q[$];
    int     errors = 0;
    int     cycles = 0;
    bit     calm = 1'b0;
    int     hold_cycles = 0;

    wind_triangle_solver uut (.*);

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic void cordic_sc(input logic [ANGLE_BITS-1:0] ang,
                                      output longint s, output longint c);
        logic [31:0] u;
        bit          neg;
        longint      x, y, z, dx, dy;
        u = {ang, {(32-ANGLE_BITS){1'b0}}};
        neg = (u[31:30] == 2'd1) || (u[31:30] == 2'd2);
        if (neg) u ^= 32'h8000_0000;
        x = CORDIC_GAIN;
        y = 0;
        z = longint'($signed(u));
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_turn(i));
            end else begin
                x += dx; y -= dy; z += longint'(atan_turn(i));
            end
        end
        if (x > Q30) x = Q30;
        if (x < -Q30) x = -Q30;
        if (y > Q30) y = Q30;
        if (y < -Q30) y = -Q30;
        if (neg) begin
            x = -x; y = -y;
        end
        s = y;
        c = x;
    endfunction

    function automatic longint asin_search(input longint m);
        longint lo, hi, mid, s, c;
        lo = 0;
        hi = longint'(1) << (ANGLE_BITS - 2);
        if (m >= Q30) return hi;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            cordic_sc(mid[ANGLE_BITS-1:0], s, c);
            if (s <= m) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, bt;
        r = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0) begin
            if (v >= r + bt) begin
                v -= r + bt; r = (r >> 1) + bt;
            end else begin
                r >>= 1;
            end
            bt >>= 2;
        end
        return r;
    endfunction

    function automatic t_wind solve_wind(input logic [15:0] h, b, t, c,
                                         input logic tok, sok);
        t_wind             w;
        logic [15:0]       drift, ang, wang;
        longint            sn, cs;
        longint unsigned   sum, term, a2, a, num, xm;
        w = '0;
        if (!tok || !sok) return w;
        drift = t - h;
        cordic_sc(drift, sn, cs);
        sum  = longint'(b) * b + longint'(c) * c;
        term = ((longint'(b) * c) * longint'(cs < 0 ? -cs : cs)) >> 29;
        if (cs >= 0) a2 = (sum > term) ? sum - term : 0;
        else a2 = sum + term;
        a = int_sqrt(a2);
        w.vld = 1'b1;
        if (a == 0) begin
            w.dir = h;
            return w;
        end
        num = (b < c) ? b : c;
        xm = (num * longint'(sn < 0 ? -sn : sn)) / a;
        if (xm > Q30) xm = Q30;
        ang = 16'(asin_search(xm));
        if (sn < 0) ang = -ang;
        wang = (b < c) ? HALF_TURN - drift - ang : ang;
        w.speed = (a > 65535) ? 16'hFFFF : a[15:0];
        w.dir = h - wang;
        return w;
    endfunction

    task automatic send_item(input logic [15:0] h, b, t, c, input logic tok, sok);
        while (!calm && $urandom_range(99) < 19) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {c, t, b, h};
        i_s_tuser  <= {sok, tok};
        do @(posedge i_clk); while (!o_s_tready);
        wind_q.push_back(solve_wind(h, b, t, c, tok, sok));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (wind_q.size() != 0) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= calm || ($urandom_range(99) >= 19);
        end
    end

    always @(posedge i_clk) begin
        t_wind exp_w;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (wind_q.size() == 0) begin
                $display("%0t: unexpected transfer %h/%h", $time, o_m_tdata, o_m_tuser);
                errors++;
            end else begin
                exp_w = wind_q.pop_front();
                if (o_m_tdata[15:0] !== exp_w.speed) begin
                    $display("%0t: speed exp %h got %h", $time, exp_w.speed,
                             o_m_tdata[15:0]);
                    errors++;
                end
                if (o_m_tdata[31:16] !== exp_w.dir) begin
                    $display("%0t: bearing exp %h got %h", $time, exp_w.dir,
                             o_m_tdata[31:16]);
                    errors++;
                end
                if (o_m_tuser[0] !== exp_w.vld) begin
                    $display("%0t: wind_valid exp %b got %b", $time, exp_w.vld,
                             o_m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    task automatic test_invalid_flags();
        send_item(16'h1234, 16'h2000, 16'h4321, 16'h1800, 1'b0, 1'b1);
        send_item(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, 1'b0);
        send_item(16'h8000, 16'h0100, 16'h0000, 16'h0000, 1'b0, 1'b0);
    endtask

    task automatic test_corner_cases();
        send_item(16'h4000, 16'h1000, 16'h4000, 16'h1000, 1'b1, 1'b1);
        send_item(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1);
        send_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
        send_item(16'h0000, 16'hFFFF, 16'h8000, 16'hFFFF, 1'b1, 1'b1);
        send_item(16'h1000, 16'h3000, 16'h1100, 16'h2000, 1'b1, 1'b1);
        send_item(16'h1000, 16'h2000, 16'h1100, 16'h3000, 1'b1, 1'b1);
        send_item(16'hF000, 16'h2000, 16'h1000, 16'h2000, 1'b1, 1'b1);
        send_item(16'h2000, 16'h1000, 16'h2001, 16'h1000, 1'b1, 1'b1);
        send_item(16'h0000, 16'h4000, 16'h4000, 16'h0000, 1'b1, 1'b1);
        send_item(16'h0000, 16'h0000, 16'hC000, 16'h4000, 1'b1, 1'b1);
        send_item(16'h7FFF, 16'h0001, 16'h8000, 16'hFFFF, 1'b1, 1'b1);
        send_item(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 1'b1, 1'b1);
        send_item(16'h0100, 16'h2000, 16'hFF00, 16'h2000, 1'b1, 1'b1);
    endtask

    task automatic send_random(input int count);
        logic [15:0] h, b, t, c;
        for (int n = 0; n < count; n++) begin
            h = 16'($urandom); t = 16'($urandom); b = 16'($urandom); c = 16'($urandom);
            case ($urandom_range(7))
                0: c = b;
                1: begin c = b; t = 16'(h + $urandom_range(3) - 1); end
                2: begin b = 16'($urandom_range(4095)); c = 16'($urandom_range(4095)); end
                3: t = 16'(h + $urandom_range(32) - 16);
                default: ;
            endcase
            send_item(h, b, t, c, $urandom_range(15) != 0, $urandom_range(15) != 0);
        end
    endtask

    task automatic test_random_idle();
        send_random(150);
        calm = 1'b1;
        send_random(100);
        calm = 1'b0;
    endtask

    task automatic test_output_stall();
        hold_cycles = 1500;
        send_random(550);
    endtask

    task automatic test_drain_pause();
        wait_drained();
        send_random(200);
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_invalid_flags();
        test_corner_cases();
        test_random_idle();
        test_output_stall();
        test_drain_pause();
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (errors == 0 && wind_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ wind_triangle_solver.f @@
hdl/wts_pkg.sv
hdl/wts_cordic.sv
hdl/wts_asin_step.sv
hdl/wind_triangle_solver.sv
test/wind_triangle_solver_tb.sv
